// File: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types, constants and helpers of the complex arithmetic unit
// Word format, operation and status codes, and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;

  // Full product width, signed sum width, quotient bits kept by the divider.
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = WORD_BITS + 1;
  localparam int REM_W  = PROD_W + FRAC_BITS;
  localparam int CMP_W  = PROD_W + FRAC_BITS + QUO_W + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic        [PROD_W-1:0]    mag_t;
  typedef logic        [REM_W-1:0]     rem_t;
  typedef logic        [QUO_W-1:0]     quo_t;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // Result of the product stages: component sums and divisor magnitude.
  typedef struct packed {
    func_t func;
    sum_t  re;
    sum_t  im;
    mag_t  den;
  } prod_res_t;

  // Sideband carried alongside the divider.
  typedef struct packed {
    logic  is_div;
    logic  dz;
    logic  neg_re;
    logic  neg_im;
    word_t re;
    word_t im;
    logic  sat;
  } side_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_word_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  // Clamp a wide signed value to the word range.
  function automatic sat_word_t sat_word(input sum_t v);
    sat_word_t r;
    if (v > sum_t'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.sat = 1'b1;
    end else if (v < sum_t'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Apply the sign to a quotient magnitude and clamp it.
  function automatic sat_word_t sat_quo(input quo_t q, input logic ovf, input logic neg);
    sat_word_t r;
    quo_t      neg_lim;
    quo_t      pos_lim;
    neg_lim = quo_t'(1) << (WORD_BITS - 1);
    pos_lim = neg_lim - quo_t'(1);
    if (neg) begin
      r.sat = ovf || (q > neg_lim);
      r.val = r.sat ? WORD_MIN : word_t'(quo_t'(0) - q);
    end else begin
      r.sat = ovf || (q > pos_lim);
      r.val = r.sat ? WORD_MAX : word_t'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cau_mult_stage.sv
// ----------------------------------------------------------------------------
// cau_mult_stage: product and sum stages
// Stage one forms the six operand products and the add/subtract result;
// stage two combines them per operation and forms the divisor magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_mult_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_func,
  input  wire cau_pkg::word_t     a_re,
  input  wire cau_pkg::word_t     a_im,
  input  wire cau_pkg::word_t     b_re,
  input  wire cau_pkg::word_t     b_im,
  output logic                    s2_valid,
  output cau_pkg::prod_res_t      s2
);
  import cau_pkg::*;

  logic  v1_r;
  func_t f1_r;
  prod_t prr_r, pii_r, pri_r, pir_r, pbr_r, pbi_r;
  sum_t  asre_r, asim_r;
  func_t f1_nxt;
  sum_t  asre_nxt, asim_nxt;

  logic      v2_r;
  prod_res_t s2_r, s2_nxt;

  always_comb begin
    f1_nxt = func_t'(in_func);
    if (f1_nxt == FN_SUB) begin
      asre_nxt = sum_t'(a_re) - sum_t'(b_re);
      asim_nxt = sum_t'(a_im) - sum_t'(b_im);
    end else begin
      asre_nxt = sum_t'(a_re) + sum_t'(b_re);
      asim_nxt = sum_t'(a_im) + sum_t'(b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= f1_nxt;
      prr_r  <= prod_t'(a_re) * prod_t'(b_re);
      pii_r  <= prod_t'(a_im) * prod_t'(b_im);
      pri_r  <= prod_t'(a_re) * prod_t'(b_im);
      pir_r  <= prod_t'(a_im) * prod_t'(b_re);
      pbr_r  <= prod_t'(b_re) * prod_t'(b_re);
      pbi_r  <= prod_t'(b_im) * prod_t'(b_im);
      asre_r <= asre_nxt;
      asim_r <= asim_nxt;
      s2_r   <= s2_nxt;
    end
  end

  // Squares are never negative, so their sum fits the unsigned product width.
  always_comb begin
    s2_nxt.func = f1_r;
    s2_nxt.den  = mag_t'(pbr_r) + mag_t'(pbi_r);
    case (f1_r)
      FN_MUL: begin
        s2_nxt.re = sum_t'(prr_r) - sum_t'(pii_r);
        s2_nxt.im = sum_t'(pri_r) + sum_t'(pir_r);
      end
      FN_DIV: begin
        s2_nxt.re = sum_t'(prr_r) + sum_t'(pii_r);
        s2_nxt.im = sum_t'(pir_r) - sum_t'(pri_r);
      end
      default: begin
        s2_nxt.re = asre_r;
        s2_nxt.im = asim_r;
      end
    endcase
  end

  assign s2_valid = v2_r;
  assign s2       = s2_r;

endmodule

`default_nettype wire

// File: rtl/cau_div_pipe.sv
// ----------------------------------------------------------------------------
// cau_div_pipe: pipelined restoring divider for both result components
// One quotient bit per stage; the first stage also flags quotients that
// exceed the kept quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire cau_pkg::side_t  in_side,
  input  wire cau_pkg::mag_t   num_re,
  input  wire cau_pkg::mag_t   num_im,
  input  wire cau_pkg::mag_t   den,
  output logic                 out_valid,
  output cau_pkg::side_t       out_side,
  output cau_pkg::quo_t        q_re,
  output cau_pkg::quo_t        q_im,
  output logic                 ovf_re,
  output logic                 ovf_im
);
  import cau_pkg::*;

  logic  vld_r  [QUO_W];
  side_t side_r [QUO_W];
  rem_t  rre_r  [QUO_W];
  rem_t  rim_r  [QUO_W];
  quo_t  qre_r  [QUO_W];
  quo_t  qim_r  [QUO_W];
  mag_t  den_r  [QUO_W];
  logic  ovre_r [QUO_W];
  logic  ovim_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic             v_in, ovre_in, ovim_in, ge_re, ge_im;
    side_t            side_in;
    rem_t             rre_in, rim_in;
    quo_t             qre_in, qim_in;
    mag_t             den_in;
    logic [CMP_W-1:0] dsh;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign rre_in  = rem_t'(num_re) << FRAC_BITS;
      assign rim_in  = rem_t'(num_im) << FRAC_BITS;
      assign qre_in  = '0;
      assign qim_in  = '0;
      assign den_in  = den;
      assign ovre_in = CMP_W'(rre_in) >= (CMP_W'(den_in) << QUO_W);
      assign ovim_in = CMP_W'(rim_in) >= (CMP_W'(den_in) << QUO_W);
    end else begin : g_next
      assign v_in    = vld_r[j-1];
      assign side_in = side_r[j-1];
      assign rre_in  = rre_r[j-1];
      assign rim_in  = rim_r[j-1];
      assign qre_in  = qre_r[j-1];
      assign qim_in  = qim_r[j-1];
      assign den_in  = den_r[j-1];
      assign ovre_in = ovre_r[j-1];
      assign ovim_in = ovim_r[j-1];
    end

    assign dsh   = CMP_W'(den_in) << K;
    assign ge_re = CMP_W'(rre_in) >= dsh;
    assign ge_im = CMP_W'(rim_in) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_in;
        den_r[j]  <= den_in;
        ovre_r[j] <= ovre_in;
        ovim_r[j] <= ovim_in;
        rre_r[j]  <= ge_re ? rem_t'(CMP_W'(rre_in) - dsh) : rre_in;
        rim_r[j]  <= ge_im ? rem_t'(CMP_W'(rim_in) - dsh) : rim_in;
        qre_r[j]  <= qre_in | (quo_t'(ge_re) << K);
        qim_r[j]  <= qim_in | (quo_t'(ge_im) << K);
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign q_re      = qre_r[QUO_W-1];
  assign q_im      = qim_r[QUO_W-1];
  assign ovf_re    = ovre_r[QUO_W-1];
  assign ovf_im    = ovim_r[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, multiply and divide
// Signed fixed-point operands, saturated results with an overflow and a
// divide-by-zero status.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_func, in_a_real, in_a_imag,
//                                   in_b_real, in_b_imag
//   out      out_valid / out_ready  out_r_real, out_r_imag, out_status
//
// One transfer is accepted every cycle while the result side keeps taking
// results. Every item passes through two product stages, one
// sign/magnitude stage, one restoring divider stage per quotient bit, and
// the output register. The divider chain sets the latency.
// The pipeline advances as one: when a result waits and out_ready is low,
// every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears the valid bits only; no state is kept between items.
`default_nettype none

module complex_arith_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_func,
  input  wire cau_pkg::word_t  in_a_real,
  input  wire cau_pkg::word_t  in_a_imag,
  input  wire cau_pkg::word_t  in_b_real,
  input  wire cau_pkg::word_t  in_b_imag,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cau_pkg::word_t       out_r_real,
  output cau_pkg::word_t       out_r_imag,
  output logic [1:0]           out_status
);
  import cau_pkg::*;

  // Global advance: the output register is free or being emptied.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Product stages.
  logic      s2_valid;
  prod_res_t s2;

  cau_mult_stage u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_func  (in_func),
    .a_re     (in_a_real),
    .a_im     (in_a_imag),
    .b_re     (in_b_real),
    .b_im     (in_b_imag),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  // Sign/magnitude stage. Add, subtract and multiply finish here; their
  // saturated words ride along the divider as sideband.
  logic      v3_r;
  side_t     side3_r, side3_nxt;
  mag_t      nre3_r, nim3_r, den3_r;
  mag_t      nre_nxt, nim_nxt;
  sum_t      abs_re, abs_im, fin_re, fin_im;
  sat_word_t sw_re, sw_im;

  always_comb begin
    abs_re  = s2.re[SUM_W-1] ? (sum_t'(0) - s2.re) : s2.re;
    abs_im  = s2.im[SUM_W-1] ? (sum_t'(0) - s2.im) : s2.im;
    nre_nxt = abs_re[PROD_W-1:0];
    nim_nxt = abs_im[PROD_W-1:0];
    // Arithmetic shift floors, which is the rounding the multiply needs.
    if (s2.func == FN_MUL) begin
      fin_re = s2.re >>> FRAC_BITS;
      fin_im = s2.im >>> FRAC_BITS;
    end else begin
      fin_re = s2.re;
      fin_im = s2.im;
    end
    sw_re            = sat_word(fin_re);
    sw_im            = sat_word(fin_im);
    side3_nxt.is_div = (s2.func == FN_DIV);
    side3_nxt.dz     = (s2.den == '0);
    side3_nxt.neg_re = s2.re[SUM_W-1];
    side3_nxt.neg_im = s2.im[SUM_W-1];
    side3_nxt.re     = sw_re.val;
    side3_nxt.im     = sw_im.val;
    side3_nxt.sat    = sw_re.sat || sw_im.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side3_nxt;
      nre3_r  <= nre_nxt;
      nim3_r  <= nim_nxt;
      den3_r  <= s2.den;
    end
  end

  // Divider chain. A zero divisor runs through it too; the result is then
  // replaced at the end, so the quotient bits of that item do not matter.
  logic  dv_valid, dv_ovre, dv_ovim;
  side_t dv_side;
  quo_t  dv_qre, dv_qim;

  cau_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_side   (side3_r),
    .num_re    (nre3_r),
    .num_im    (nim3_r),
    .den       (den3_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .q_re      (dv_qre),
    .q_im      (dv_qim),
    .ovf_re    (dv_ovre),
    .ovf_im    (dv_ovim)
  );

  // Final selection and output register.
  logic      out_valid_r;
  word_t     re_r, im_r, re_nxt, im_nxt;
  status_t   st_r, st_nxt;
  sat_word_t dq_re, dq_im;

  always_comb begin
    dq_re = sat_quo(dv_qre, dv_ovre, dv_side.neg_re);
    dq_im = sat_quo(dv_qim, dv_ovim, dv_side.neg_im);
    if (!dv_side.is_div) begin
      re_nxt = dv_side.re;
      im_nxt = dv_side.im;
      st_nxt = dv_side.sat ? ST_OVF : ST_OK;
    end else if (dv_side.dz) begin
      re_nxt = '0;
      im_nxt = '0;
      st_nxt = ST_DZ;
    end else begin
      re_nxt = dq_re.val;
      im_nxt = dq_im.val;
      st_nxt = (dq_re.sat || dq_im.sat) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_r_real = re_r;
  assign out_r_imag = im_r;
  assign out_status = st_r;

  // A divide-by-zero result is always zero.
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DZ) |-> (out_r_real == '0) && (out_r_imag == '0))
    else $error("divide-by-zero result is not zero");

  // An overflow status means some component sits at a rail.
  a_ovf_rail : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OVF) |->
      (out_r_real == WORD_MAX) || (out_r_real == WORD_MIN) ||
      (out_r_imag == WORD_MAX) || (out_r_imag == WORD_MIN))
    else $error("overflow status without a saturated component");

  // The unused status code never appears.
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_OVF) || (out_status == ST_DZ))
    else $error("undefined status code");

  // Reset empties the output register.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
